// File: rtl/sbus_frame_stick_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// sbus frame stick decoder assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_STICK_DECODER_TOP_MACROS_SVH
`define SBUS_FRAME_STICK_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define SBFSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbfsd same-cycle check failed");

// next-cycle implication
`define SBFSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbfsd next-cycle check failed");

`endif

// File: rtl/sbfsd_pkg.sv
// ----------------------------------------------------------------------------
// sbfsd_pkg
// types, constants and the stick filter shared by the frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package sbfsd_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int STORED_BYTES = 12;
    localparam int CH_W         = 11;
    localparam int STICK_W      = 12;
    localparam int RAW_CHANS    = 8;
    localparam int RAW_BITS     = CH_W * RAW_CHANS;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int IDX_W        = $clog2(STORED_BYTES);
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int BAND_W       = 10;

    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] FOOTER_BYTE = 8'h00;
    localparam logic signed [STICK_W-1:0] STICK_FORBID = -12'sd960;

    localparam logic [CH_W-1:0]   CENTRE_RESET = 11'd1024;
    localparam logic [CH_W-1:0]   LIMIT_RESET  = 11'd660;
    localparam logic [BAND_W-1:0] BAND_RESET   = 10'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTRE = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_BAND   = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [STICK_W-1:0] stick_right_horizontal;
        logic signed [STICK_W-1:0] stick_left_vertical;
        logic signed [STICK_W-1:0] stick_right_vertical;
        logic signed [STICK_W-1:0] stick_left_horizontal;
        logic [CH_W-1:0]           switch_left;
        logic [CH_W-1:0]           switch_right;
        logic [CH_W-1:0]           aux_first;
        logic [CH_W-1:0]           aux_second;
        logic                      frame_good;
    } t_out_item;

    typedef struct packed {
        logic                good;
        logic [RAW_BITS-1:0] chans;
    } t_frame_item;

    typedef struct packed {
        logic        push;
        t_frame_item item;
    } t_q_wr;

    typedef struct packed {
        logic        valid;
        t_frame_item item;
    } t_q_rd;

    typedef struct packed {
        logic [CH_W-1:0]   centre;
        logic [CH_W-1:0]   limit;
        logic [BAND_W-1:0] band;
    } t_cfg;

    function automatic logic signed [STICK_W-1:0] stick_filter(
        input logic [CH_W-1:0]   raw,
        input t_cfg              cfg,
        input logic              third
    );
        logic signed [STICK_W-1:0] v;
        logic [CH_W-1:0]           mag;
        logic                      zero;
        v    = $signed({1'b0, raw}) - $signed({1'b0, cfg.centre});
        mag  = v[STICK_W-1] ? CH_W'(-v) : v[CH_W-1:0];
        zero = (mag <= {1'b0, cfg.band}) || (third && (v == STICK_FORBID))
               || (mag > cfg.limit);
        return zero ? '0 : v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sbus_frame_stick_decoder_top.sv
// ----------------------------------------------------------------------------
// sbus_frame_stick_decoder_top
// decodes 25-byte serial frames into four filtered sticks and four raw channels
// ----------------------------------------------------------------------------
// One received byte is taken per clock when o_in_stall stays low; the byte
// front end keeps the frame position and the first twelve bytes, and on the
// last byte of a frame hands one frame item to a two-entry queue. The back
// end pops one item per cycle while the output is not stalled, so frames
// sustain one byte per cycle while o_in_stall stays low. The result beat is
// registered when the back end pops the queued frame item. Every frame
// end gives exactly one result; a bad header or footer reports frame_good low
// with the previously held values. Registers are written through the config
// port, which is always ready, and must only change while no frame is in
// flight.
`default_nettype none

module sbus_frame_stick_decoder_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  sbfsd_pkg::t_in_item                  i_in,
    output logic                                 o_in_stall,
    output logic                                 o_out_valid,
    output sbfsd_pkg::t_out_item                 o_out,
    input  wire                                  i_out_stall,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [sbfsd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [sbfsd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    sbfsd_pkg::t_cfg  r_cfg;
    sbfsd_pkg::t_q_wr q_wr;
    sbfsd_pkg::t_q_rd q_rd;
    logic             q_full;
    logic             q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre <= sbfsd_pkg::CENTRE_RESET;
            r_cfg.limit  <= sbfsd_pkg::LIMIT_RESET;
            r_cfg.band   <= sbfsd_pkg::BAND_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sbfsd_pkg::CFG_CENTRE: begin
                    r_cfg.centre <= i_cfg_data;
                end
                sbfsd_pkg::CFG_LIMIT: begin
                    r_cfg.limit <= i_cfg_data;
                end
                sbfsd_pkg::CFG_BAND: begin
                    r_cfg.band <= i_cfg_data[sbfsd_pkg::BAND_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sbfsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr)
    );

    sbfsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_rd    (q_rd)
    );

    sbfsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rd        (q_rd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: rtl/sbfsd_front.sv
// ----------------------------------------------------------------------------
// sbfsd_front
// tracks the byte position, captures header and channel bytes, and queues
// one frame item with its header and footer check on the last byte
// ----------------------------------------------------------------------------
`default_nettype none

module sbfsd_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  sbfsd_pkg::t_in_item     i_in,
    input  wire                     i_q_full,
    output sbfsd_pkg::t_q_wr        o_q_wr
);

    logic [sbfsd_pkg::POS_W-1:0] r_pos;
    logic [sbfsd_pkg::POS_W-1:0] n_pos;
    logic [7:0]                  r_data [sbfsd_pkg::STORED_BYTES];

    logic                        accept;
    logic                        take;
    logic                        last;
    logic [sbfsd_pkg::POS_W-1:0] pos_eff;

    assign accept  = i_in_valid && !i_q_full;
    assign take    = accept && (i_in.frame_start || (r_pos != '0));
    assign pos_eff = i_in.frame_start ? '0 : r_pos;
    assign last    = pos_eff == sbfsd_pkg::POS_W'(sbfsd_pkg::FRAME_BYTES - 1);

    always_comb begin
        n_pos = r_pos;
        if (take) begin
            n_pos = last ? '0 : pos_eff + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && (pos_eff < sbfsd_pkg::POS_W'(sbfsd_pkg::STORED_BYTES))) begin
            r_data[pos_eff[sbfsd_pkg::IDX_W-1:0]] <= i_in.rx_byte;
        end
    end

    always_comb begin
        o_q_wr.push      = take && last;
        o_q_wr.item.good = (r_data[0] == sbfsd_pkg::HEADER_BYTE)
                           && (i_in.rx_byte == sbfsd_pkg::FOOTER_BYTE);
        for (int b = 1; b < sbfsd_pkg::STORED_BYTES; b++) begin
            o_q_wr.item.chans[(b-1)*8 +: 8] = r_data[b];
        end
    end

endmodule

`default_nettype wire

// File: rtl/sbfsd_queue.sv
// ----------------------------------------------------------------------------
// sbfsd_queue
// two-entry frame item queue between the byte front end and the decode back end
// ----------------------------------------------------------------------------
`default_nettype none

module sbfsd_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  sbfsd_pkg::t_q_wr        i_wr,
    input  wire                     i_pop,
    output logic                    o_full,
    output sbfsd_pkg::t_q_rd        o_rd
);

    sbfsd_pkg::t_frame_item        r_mem [sbfsd_pkg::Q_DEPTH];
    logic [sbfsd_pkg::Q_PTR_W-1:0] r_wptr;
    logic [sbfsd_pkg::Q_PTR_W-1:0] r_rptr;
    logic [sbfsd_pkg::Q_CNT_W-1:0] r_cnt;
    logic [sbfsd_pkg::Q_PTR_W-1:0] n_wptr;
    logic [sbfsd_pkg::Q_PTR_W-1:0] n_rptr;
    logic [sbfsd_pkg::Q_CNT_W-1:0] n_cnt;

    logic do_push;
    logic do_pop;

    assign o_full   = r_cnt == sbfsd_pkg::Q_CNT_W'(sbfsd_pkg::Q_DEPTH);
    assign do_push  = i_wr.push && !o_full;
    assign do_pop   = i_pop && (r_cnt != '0);
    assign o_rd.valid = r_cnt != '0;
    assign o_rd.item  = r_mem[r_rptr];

    always_comb begin
        n_wptr = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = do_pop  ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wr.item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sbfsd_back.sv
// ----------------------------------------------------------------------------
// sbfsd_back
// centres and filters the sticks, updates the held channels on a good frame
// and presents one result beat per frame
// ----------------------------------------------------------------------------
`default_nettype none

module sbfsd_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  sbfsd_pkg::t_cfg         i_cfg,
    input  sbfsd_pkg::t_q_rd        i_rd,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output sbfsd_pkg::t_out_item    o_out
);

    logic signed [sbfsd_pkg::STICK_W-1:0] r_stick [4];
    logic [sbfsd_pkg::CH_W-1:0]           r_raw   [4];
    logic                                 r_good;
    logic                                 r_out_valid;

    logic signed [sbfsd_pkg::STICK_W-1:0] stick_new [4];

    assign o_pop = i_rd.valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            stick_new[k] = sbfsd_pkg::stick_filter(
                i_rd.item.chans[k*sbfsd_pkg::CH_W +: sbfsd_pkg::CH_W], i_cfg, k == 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_good      <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_stick[k] <= '0;
                r_raw[k]   <= '0;
            end
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_good      <= i_rd.item.good;
                if (i_rd.item.good) begin
                    for (int k = 0; k < 4; k++) begin
                        r_stick[k] <= stick_new[k];
                        r_raw[k]   <= i_rd.item.chans[(k+4)*sbfsd_pkg::CH_W +: sbfsd_pkg::CH_W];
                    end
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out.stick_right_horizontal = r_stick[0];
        o_out.stick_left_vertical    = r_stick[1];
        o_out.stick_right_vertical   = r_stick[2];
        o_out.stick_left_horizontal  = r_stick[3];
        o_out.switch_left            = r_raw[0];
        o_out.switch_right           = r_raw[1];
        o_out.aux_first              = r_raw[2];
        o_out.aux_second             = r_raw[3];
        o_out.frame_good             = r_good;
    end

endmodule

`default_nettype wire

// File: rtl/sbfsd_checker.sv
// ----------------------------------------------------------------------------
// sbfsd_checker
// port-level checks on the frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sbus_frame_stick_decoder_top_macros.svh"

module sbfsd_checker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  sbfsd_pkg::t_in_item                  i_in,
    input  wire                                  o_in_stall,
    input  wire                                  o_out_valid,
    input  sbfsd_pkg::t_out_item                 o_out,
    input  wire                                  i_out_stall,
    input  wire                                  i_cfg_valid,
    input  wire                                  o_cfg_ready,
    input  wire  [sbfsd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [sbfsd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic unused_inputs;
    logic third_forbidden;
    assign unused_inputs = i_in_valid ^ (^i_in) ^ o_in_stall ^ (^i_cfg_index) ^ (^i_cfg_data);
    assign third_forbidden = o_out.stick_right_vertical == sbfsd_pkg::STICK_FORBID;

    `SBFSD_ASSERT_NEXT(a_out_valid_held, o_out_valid && i_out_stall, o_out_valid)
    `SBFSD_ASSERT_NEXT(a_out_beat_held, o_out_valid && i_out_stall, $stable(o_out))
    `SBFSD_ASSERT_NOW(a_cfg_always_ready, i_cfg_valid, (o_cfg_ready && !unused_inputs) || o_cfg_ready)
    `SBFSD_ASSERT_NOW(a_third_stick_not_forbidden, o_out_valid, !third_forbidden)

endmodule

bind sbus_frame_stick_decoder_top sbfsd_checker u_sbfsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in        (i_in),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out       (o_out),
    .i_out_stall (i_out_stall),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire
